### sv/ttt_pkg.sv
// ============================================================================
// ttt_pkg
// Shared types and constants of the transmit timestamp tag tracker.
// ============================================================================
package ttt_pkg;

    localparam int SLOTS    = 32;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TAG_W    = 16;
    localparam int NS_W     = 30;
    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
    localparam logic [TAG_W-1:0] TAG_RESET = 16'd1;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_STAMP = 2'd1,
        CMD_SWEEP = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        K_ASSIGNED  = 3'd0,
        K_BUSY      = 3'd1,
        K_DELIVERED = 3'd2,
        K_NOMATCH   = 3'd3,
        K_EXPIRED   = 3'd4,
        K_DONE      = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_EMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] packet_handle;
        logic [15:0] stamp_tag;
        logic [31:0] stamp_seconds;
        logic [31:0] stamp_low_word;
        logic [31:0] now_us;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_tag;
        logic [15:0] out_handle;
        logic [31:0] out_seconds;
        logic [29:0] out_nanoseconds;
        logic        any_pending;
        logic        last;
    } t_out;

endpackage

### sv/ttt_if.sv
// ============================================================================
// ttt_if
// Valid/ready channel carrying one payload.
// ============================================================================
interface ttt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/tx_timestamp_tag_tracker_core.sv
// ============================================================================
// tx_timestamp_tag_tracker_core
// Table of pending transmit-timestamp requests with tag match and timeout.
// ============================================================================
// Slot tags, handles and start times live in one synchronous memory. The
// active bits and a copy of the tags are flip-flops, so the lowest free or
// matching slot is found by a priority encode. An allocate or a timestamp
// passes through accept, search, then memory read and write back. The
// next transaction is accepted only once the result has been taken. A sweep
// reads each slot from memory and then checks its age, and it holds on an
// expired slot for as long as the previous result still waits at the sink.
module tx_timestamp_tag_tracker_core import ttt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ttt_if.sink             cfg,
    ttt_if.sink             in_ch,
    ttt_if.source           out_ch
);
    logic [63:0] mem [SLOTS];
    logic [63:0] r_rd;
    logic [SLOTS-1:0] r_active, n_active;
    logic [31:0] r_timeout;
    logic [TAG_W-1:0] r_tagc, n_tagc;
    t_state r_state, n_state;
    t_in    r_in;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic   r_hit, n_hit;
    logic   r_pend, n_pend;
    logic   r_ov, n_ov;
    t_out   r_out, n_out;

    // Tags are also kept in flip-flops for the parallel match.
    logic [TAG_W-1:0] r_tags [SLOTS];

    logic   hit_any;
    logic [SLOT_W-1:0] hit_idx;
    logic   we;
    logic [63:0] wdata;
    logic [SLOT_W-1:0] rd_addr;
    logic [TAG_W-1:0] t_next;
    logic [31:0] age;
    logic   out_free;

    function automatic logic mem_tag_ok(input int i);
        return r_tags[i] == r_in.stamp_tag;
    endfunction

    assign out_free = !r_ov || out_ch.ready;
    assign cfg.ready = (r_state == S_IDLE);
    assign in_ch.ready = (r_state == S_IDLE) && !r_ov;
    assign out_ch.valid = r_ov;
    assign out_ch.data = r_out;

    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_in.command == CMD_ALLOC ? !r_active[i] :
                (r_active[i] && mem_tag_ok(i))) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
    end

    assign t_next = (r_tagc + 1'b1 == '0) ? TAG_RESET : TAG_W'(r_tagc + 1'b1);
    assign age = r_in.now_us - r_rd[63:32];
    assign rd_addr = n_idx;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_hit = r_hit;
        n_pend = r_pend;
        case (r_state)
            S_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    n_state = (in_ch.data.command == CMD_NONE) ? S_IDLE : S_SCAN;
                    n_idx = '0;
                    n_pend = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_in.command == CMD_SWEEP) begin
                    n_state = S_EVAL;
                    n_idx = '0;
                end else begin
                    n_hit = hit_any;
                    n_idx = hit_idx;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_in.command != CMD_SWEEP) begin
                    if (out_free) n_state = S_IDLE;
                end else begin
                    if (r_active[r_idx]) n_pend = 1'b1;
                    if (r_active[r_idx] && age > r_timeout && !out_free) begin
                        n_state = S_EVAL;
                    end else if (r_idx == SLOT_W'(SLOTS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: n_state = S_EVAL;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out = r_out;
        n_ov = r_ov && !out_ch.ready;
        n_active = r_active;
        n_tagc = r_tagc;
        we = 1'b0;
        wdata = {r_in.now_us, r_in.packet_handle, t_next};
        case (r_state)
            S_EVAL: begin
                if (r_in.command == CMD_ALLOC && out_free) begin
                    n_ov = 1'b1;
                    n_out = '0;
                    n_out.last = 1'b1;
                    if (r_hit) begin
                        n_out.kind = K_ASSIGNED;
                        n_out.out_tag = t_next;
                        n_tagc = t_next;
                        n_active[r_idx] = 1'b1;
                        we = 1'b1;
                    end else begin
                        n_out.kind = K_BUSY;
                    end
                end else if (r_in.command == CMD_STAMP && out_free) begin
                    n_ov = 1'b1;
                    n_out = '0;
                    n_out.last = 1'b1;
                    n_out.out_tag = r_in.stamp_tag;
                    if (r_hit) begin
                        n_out.kind = K_DELIVERED;
                        n_out.out_handle = r_rd[31:16];
                        n_out.out_seconds = r_in.stamp_seconds;
                        n_out.out_nanoseconds = r_in.stamp_low_word[NS_W-1:0];
                        n_active[r_idx] = 1'b0;
                    end else begin
                        n_out.kind = K_NOMATCH;
                    end
                end else if (r_in.command == CMD_SWEEP && out_free &&
                             r_active[r_idx] && age > r_timeout) begin
                    n_ov = 1'b1;
                    n_out = '0;
                    n_out.kind = K_EXPIRED;
                    n_out.out_tag = r_rd[15:0];
                    n_out.out_handle = r_rd[31:16];
                    n_active[r_idx] = 1'b0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_out = '0;
                    n_out.kind = K_DONE;
                    n_out.any_pending = r_pend;
                    n_out.last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_idx] <= wdata;
            r_tags[r_idx] <= t_next;
        end
        r_rd <= mem[rd_addr];
        if (r_state == S_IDLE && in_ch.valid && in_ch.ready) r_in <= in_ch.data;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_active <= '0;
            r_timeout <= TIMEOUT_RESET;
            r_tagc <= TAG_RESET;
            r_ov <= 1'b0;
            r_idx <= '0;
            r_hit <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_active <= n_active;
            r_tagc <= n_tagc;
            r_ov <= n_ov;
            r_idx <= n_idx;
            r_hit <= n_hit;
            r_pend <= n_pend;
            if (cfg.valid && cfg.ready) r_timeout <= cfg.data;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !out_ch.ready |=> r_ov && $stable(r_out)) else $error("out lost");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_alloc_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> r_active[$past(r_idx)]) else $error("slot not set");
endmodule

### tb/tx_timestamp_tag_tracker_core_test.sv
// ============================================================================
// tx_timestamp_tag_tracker_core_test
// Drives allocate, timestamp, sweep and no-op commands into the tag tracker under
// random source and sink idling, predicts each result from a local copy of
// the slot table and compares every field of every result in order.
// ============================================================================
`timescale 1ns / 100ps
module tx_timestamp_tag_tracker_core_test import ttt_pkg::*; ();

    localparam int SETTLE_CYCLES = 48;
    localparam int STALL_LIMIT   = 4000;

    logic i_clk;
    logic i_rst_n;

    ttt_if #(.T(logic [31:0])) cfg ();
    ttt_if #(.T(t_in))         in_ch ();
    ttt_if #(.T(t_out))        out_ch ();

    tx_timestamp_tag_tracker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    logic              tbl_active [SLOTS];
    logic [TAG_W-1:0]  tbl_tag    [SLOTS];
    logic [15:0]       tbl_handle [SLOTS];
    logic [31:0]       tbl_start  [SLOTS];
    logic [TAG_W-1:0]  next_tag;
    logic [31:0]       timeout_reg;
    logic [31:0]       clock_us;

    t_out pending_results [$];
    int   src_idle_pct;
    int   snk_idle_pct;
    int   errors;
    int   items_sent;
    int   results_seen;
    int   kind_seen [6];
    int   quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out blank_result(t_kind k, logic [TAG_W-1:0] tag);
        t_out r;
        r = '0;
        r.kind = k;
        r.out_tag = tag;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void predict_tracker(t_in x);
        t_out r;
        int   slot;
        logic pend;
        slot = -1;
        case (t_cmd'(x.command))
            CMD_ALLOC: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!tbl_active[i]) slot = i;
                if (slot < 0) begin
                    pending_results.push_back(blank_result(K_BUSY, '0));
                end else begin
                    next_tag = next_tag + 1'b1;
                    if (next_tag == '0) next_tag = TAG_W'(1);
                    tbl_tag[slot] = next_tag;
                    tbl_handle[slot] = x.packet_handle;
                    tbl_start[slot] = x.now_us;
                    tbl_active[slot] = 1'b1;
                    pending_results.push_back(blank_result(K_ASSIGNED, next_tag));
                end
            end
            CMD_STAMP: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tbl_active[i] && tbl_tag[i] == x.stamp_tag) slot = i;
                if (slot < 0) begin
                    pending_results.push_back(blank_result(K_NOMATCH, x.stamp_tag));
                end else begin
                    tbl_active[slot] = 1'b0;
                    r = blank_result(K_DELIVERED, x.stamp_tag);
                    r.out_handle = tbl_handle[slot];
                    r.out_seconds = x.stamp_seconds;
                    r.out_nanoseconds = x.stamp_low_word[NS_W-1:0];
                    pending_results.push_back(r);
                end
            end
            CMD_SWEEP: begin
                pend = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_active[i]) begin
                        pend = 1'b1;
                        if (x.now_us - tbl_start[i] > timeout_reg) begin
                            tbl_active[i] = 1'b0;
                            r = blank_result(K_EXPIRED, tbl_tag[i]);
                            r.out_handle = tbl_handle[i];
                            r.last = 1'b0;
                            pending_results.push_back(r);
                        end
                    end
                end
                r = blank_result(K_DONE, '0);
                r.any_pending = pend;
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(t_in x);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= x;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        predict_tracker(x);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.data <= value;
        do @(posedge i_clk); while (!(cfg.valid && cfg.ready));
        cfg.valid <= 1'b0;
        timeout_reg = value;
    endtask

    function automatic t_in make_item(t_cmd c);
        t_in x;
        int  pick;
        x.command = c;
        x.packet_handle = 16'($urandom);
        x.stamp_seconds = $urandom;
        x.stamp_low_word = $urandom;
        x.stamp_tag = TAG_W'($urandom);
        clock_us = clock_us + $urandom_range(0, 400);
        x.now_us = clock_us;
        if (c == CMD_STAMP && $urandom_range(99) < 80) begin
            pick = $urandom_range(SLOTS - 1);
            for (int i = 0; i < SLOTS; i++)
                if (tbl_active[(pick + i) % SLOTS]) begin
                    x.stamp_tag = tbl_tag[(pick + i) % SLOTS];
                    break;
                end
        end
        return x;
    endfunction

    task automatic test_directed();
        t_in x;
        x = make_item(CMD_SWEEP);
        send_item(x);
        x = make_item(CMD_STAMP);
        x.stamp_tag = 16'hFFFF;
        send_item(x);
        x = make_item(CMD_ALLOC);
        x.packet_handle = 16'hFFFF;
        x.now_us = 32'hFFFF_FFF0;
        send_item(x);
        x = make_item(CMD_ALLOC);
        x.packet_handle = 16'h0000;
        x.now_us = 32'h0000_0000;
        send_item(x);
        x = make_item(CMD_NONE);
        send_item(x);
        x = make_item(CMD_STAMP);
        x.stamp_tag = 16'd2;
        x.stamp_seconds = 32'hFFFF_FFFF;
        x.stamp_low_word = 32'hFFFF_FFFF;
        send_item(x);
        x = make_item(CMD_STAMP);
        x.stamp_tag = 16'd2;
        send_item(x);
        x = make_item(CMD_SWEEP);
        x.now_us = 32'd10000;
        send_item(x);
        x = make_item(CMD_SWEEP);
        x.now_us = 32'd10001;
        send_item(x);
        write_timeout(32'd0);
        x = make_item(CMD_ALLOC);
        x.now_us = 32'd500;
        send_item(x);
        x.command = CMD_SWEEP;
        send_item(x);
        x.now_us = 32'd501;
        send_item(x);
        x = make_item(CMD_STAMP);
        x.stamp_seconds = '0;
        x.stamp_low_word = '0;
        x.stamp_tag = '0;
        send_item(x);
    endtask

    task automatic test_table_full();
        t_in x;
        for (int i = 0; i < SLOTS + 3; i++) begin
            x = make_item(CMD_ALLOC);
            send_item(x);
        end
        x = make_item(CMD_SWEEP);
        x.now_us = clock_us + 32'h8000_0000;
        send_item(x);
    endtask

    task automatic test_random_traffic(int count);
        int   roll;
        t_cmd c;
        t_in  x;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 42) c = CMD_ALLOC;
            else if (roll < 80) c = CMD_STAMP;
            else if (roll < 95) c = CMD_SWEEP;
            else c = CMD_NONE;
            x = make_item(c);
            if ($urandom_range(99) < 5) x.now_us = $urandom;
            x.command = c;
            send_item(x);
            if (n == count / 2) wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (out_ch.data.kind <= K_DONE) kind_seen[out_ch.data.kind]++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, out_ch.data);
                end else begin
                    t_out e;
                    e = pending_results.pop_front();
                    if (e.kind != out_ch.data.kind) begin
                        errors++;
                        $display("%0t: kind exp %0d got %0d", $time, e.kind,
                                 out_ch.data.kind);
                    end
                    if (e.out_tag != out_ch.data.out_tag) begin
                        errors++;
                        $display("%0t: tag exp %h got %h", $time, e.out_tag,
                                 out_ch.data.out_tag);
                    end
                    if (e.out_handle != out_ch.data.out_handle) begin
                        errors++;
                        $display("%0t: handle exp %h got %h", $time, e.out_handle,
                                 out_ch.data.out_handle);
                    end
                    if (e.out_seconds != out_ch.data.out_seconds) begin
                        errors++;
                        $display("%0t: seconds exp %h got %h", $time, e.out_seconds,
                                 out_ch.data.out_seconds);
                    end
                    if (e.out_nanoseconds != out_ch.data.out_nanoseconds) begin
                        errors++;
                        $display("%0t: nanoseconds exp %h got %h", $time,
                                 e.out_nanoseconds, out_ch.data.out_nanoseconds);
                    end
                    if (e.any_pending != out_ch.data.any_pending) begin
                        errors++;
                        $display("%0t: pending exp %b got %b", $time, e.any_pending,
                                 out_ch.data.any_pending);
                    end
                    if (e.last != out_ch.data.last) begin
                        errors++;
                        $display("%0t: last exp %b got %b", $time, e.last,
                                 out_ch.data.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg.valid && cfg.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tx_timestamp_tag_tracker_core_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_active[i] = 1'b0;
            tbl_tag[i] = '0;
            tbl_handle[i] = '0;
            tbl_start[i] = '0;
        end
        next_tag = TAG_RESET;
        timeout_reg = TIMEOUT_RESET;
        clock_us = 32'd20000;
        src_idle_pct = 29;
        snk_idle_pct = 51;
        i_rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_timeout(32'hFFFF_FFFF);
        test_table_full();
        write_timeout(32'd600);
        test_random_traffic(60);

        src_idle_pct = 51;
        snk_idle_pct = 29;
        write_timeout(32'd1);
        test_random_traffic(50);
        write_timeout(32'd2000);
        test_random_traffic(20);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_timeout(32'd900);
        test_random_traffic(50);

        wait_drained();
        $display("Sent %0d commands across three idling profiles and several timeouts.",
                 items_sent);
        $display("Checked %0d results: assigned %0d busy %0d delivered %0d",
                 results_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("  nomatch %0d expired %0d done %0d.",
                 kind_seen[3], kind_seen[4], kind_seen[5]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tx_timestamp_tag_tracker_core_test OK");
        end else begin
            $display("tx_timestamp_tag_tracker_core_test NOT OK");
        end
        $finish;
    end

endmodule
